>>> rtl/mdg_pkg.sv
// ----------------------------------------------------------------------------
// mdg_pkg
// Shared constants, codes and helper functions of the maze generator: command
// and register codes, wall bits, direction codes, the random step and the
// candidate pick.
// ----------------------------------------------------------------------------
package mdg_pkg;

   localparam int MDG_MAX_ROWS = 32;
   localparam int MDG_MAX_COLS = 32;

   localparam int CFG_W   = 6;
   localparam int IDX_W   = 5;
   localparam int WALL_W  = 4;
   localparam int SEED_W  = 32;

   // Command codes carried on req_tuser.
   localparam logic CMD_GENERATE = 1'b0;
   localparam logic CMD_READ     = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_ROWS_USED = 1'b0;
   localparam logic CSR_COLS_USED = 1'b1;

   // Direction codes, also the bit position of the matching wall.
   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   localparam logic [WALL_W-1:0] WALLS_ALL  = 4'hF;
   localparam logic [WALL_W-1:0] WALLS_NONE = 4'h0;

   localparam logic [SEED_W-1:0] LFSR_MASK = 32'hD000_0001;

   function automatic logic [WALL_W-1:0] wall_bit(input logic [1:0] dir);
      return WALL_W'(1) << dir;
   endfunction

   // Up pairs with down and left with right.
   function automatic logic [1:0] opposite(input logic [1:0] dir);
      return dir ^ 2'd1;
   endfunction

   function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] v);
      logic [SEED_W-1:0] s;
      s = v >> 1;
      if (v[0]) begin
         s = s ^ LFSR_MASK;
      end
      return s;
   endfunction

   // Residue modulo 3 by folding: 2^16, 2^8, 2^4 and 2^2 are all 1 mod 3.
   function automatic logic [1:0] mod3(input logic [SEED_W-1:0] v);
      logic [16:0] s1;
      logic [9:0]  s2;
      logic [5:0]  s3;
      logic [3:0]  s4;
      logic [3:0]  s5;
      s1 = {1'b0, v[31:16]} + {1'b0, v[15:0]};
      s2 = {1'b0, s1[16:8]} + {2'b00, s1[7:0]};
      s3 = s2[9:4] + {2'b00, s2[3:0]};
      s4 = {2'b00, s3[5:4]} + {2'b00, s3[3:2]} + {2'b00, s3[1:0]};
      if (s4 >= 4'd6) begin
         s5 = s4 - 4'd6;
      end else if (s4 >= 4'd3) begin
         s5 = s4 - 4'd3;
      end else begin
         s5 = s4;
      end
      return s5[1:0];
   endfunction

   // Random value modulo the candidate count (1 to 4).
   function automatic logic [1:0] pick_index(input logic [SEED_W-1:0] v,
                                             input logic [2:0] count);
      logic [1:0] idx;
      case (count)
         3'd2:    idx = {1'b0, v[0]};
         3'd3:    idx = mod3(v);
         3'd4:    idx = v[1:0];
         default: idx = 2'd0;
      endcase
      return idx;
   endfunction

   // Direction of the idx-th set bit, counting in the order up, down, left, right.
   function automatic logic [1:0] nth_dir(input logic [3:0] cand, input logic [1:0] idx);
      logic [1:0] seen;
      logic [1:0] dir;
      seen = 2'd0;
      dir  = DIR_UP;
      for (int j = 0; j < 4; j++) begin
         if (cand[j]) begin
            if (seen == idx) begin
               dir = 2'(j);
            end
            seen = seen + 2'd1;
         end
      end
      return dir;
   endfunction

endpackage

>>> rtl/mdg_ram.sv
// ----------------------------------------------------------------------------
// mdg_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module mdg_ram #(
   parameter int WIDTH  = 4,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/maze_dfs_generator.sv
// ----------------------------------------------------------------------------
// maze_dfs_generator
// Perfect maze generator by depth-first carving with a position stack, and a
// read port for the wall bits of single cells.
// ----------------------------------------------------------------------------
// A read transaction (tuser 1) returns the wall bits of one cell, and the
// next one is accepted only once that result is registered. A generate
// transaction (tuser 0) first sweeps the wall memory back to all walls, one
// entry a cycle, then walks the grid. Each walk step reads the current cell
// and its neighbors inside the grid through the single read port of the wall
// memory and then decides; a forward step then makes a random step, picks a
// direction and does two wall writes, and a backtrack reads the stack. After
// reset the same sweep runs before the first transaction is accepted;
// configuration writes are taken throughout.
module maze_dfs_generator
#(
   parameter int MAX_ROWS = mdg_pkg::MDG_MAX_ROWS,
   parameter int MAX_COLS = mdg_pkg::MDG_MAX_COLS
) (
   input  logic                      clock,
   input  logic                      reset,
   // Request channel.
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // Fields from bit 0: seed[31:0], row_index[36:32], col_index[41:37].
   input  logic [47:0]               req_tdata,
   // Fields from bit 0: cmd.
   input  logic                      req_tuser,
   // Response channel.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // Fields from bit 0: walls[3:0].
   output logic [7:0]                rsp_tdata,
   // Fields from bit 0: gen_done.
   output logic                      rsp_tuser,
   // Configuration write port.
   input  logic                      csr_wr_en,
   input  logic                      csr_index,
   input  logic [mdg_pkg::CFG_W-1:0] csr_wdata
);

   import mdg_pkg::*;

   localparam int CELLS = MAX_ROWS * MAX_COLS;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RCW   = $clog2(MAX_ROWS + 1);
   localparam int CCW   = $clog2(MAX_COLS + 1);
   localparam int SDW   = $clog2(CELLS + 1);

   typedef enum logic [14:0] {
      ST_IDLE      = 15'b000000000000001,
      ST_RD_DATA   = 15'b000000000000010,
      ST_CLEAR     = 15'b000000000000100,
      ST_SCAN      = 15'b000000000001000,
      ST_DECIDE    = 15'b000000000010000,
      ST_PICK_LFSR = 15'b000000000100000,
      ST_PICK_MOD  = 15'b000000001000000,
      ST_CARVE_HERE= 15'b000000010000000,
      ST_CARVE_NEXT= 15'b000000100000000,
      ST_POP       = 15'b000001000000000,
      ST_POP_LOAD  = 15'b000010000000000,
      ST_FIN_RD0   = 15'b000100000000000,
      ST_FIN_WR0   = 15'b001000000000000,
      ST_FIN_RD1   = 15'b010000000000000,
      ST_FIN_WR1   = 15'b100000000000000
   } state_type;

   function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
      return AW'(int'(r) * MAX_COLS + int'(c));
   endfunction

   function automatic logic [RW-1:0] step_row(input logic [RW-1:0] r, input logic [1:0] dir);
      logic [RW-1:0] nr;
      nr = r;
      if (dir == DIR_UP) begin
         nr = r - RW'(1);
      end else if (dir == DIR_DOWN) begin
         nr = r + RW'(1);
      end
      return nr;
   endfunction

   function automatic logic [CW-1:0] step_col(input logic [CW-1:0] c, input logic [1:0] dir);
      logic [CW-1:0] nc;
      nc = c;
      if (dir == DIR_LEFT) begin
         nc = c - CW'(1);
      end else if (dir == DIR_RIGHT) begin
         nc = c + CW'(1);
      end
      return nc;
   endfunction

   // Registers.
   state_type         state_ff, state_in;
   logic [2:0]        probe_ff, probe_in;
   logic [3:0]        fresh_ff, fresh_in;
   logic [WALL_W-1:0] here_ff, here_in;
   logic [1:0]        dir_ff, dir_in;
   logic [SEED_W-1:0] lfsr_ff, lfsr_in;
   logic [SDW-1:0]    depth_ff, depth_in;
   logic [RW-1:0]     cur_row_ff, cur_row_in;
   logic [CW-1:0]     cur_col_ff, cur_col_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic              gen_ff, gen_in;
   logic              oob_ff, oob_in;
   logic [CFG_W-1:0]  rows_ff, rows_in;
   logic [CFG_W-1:0]  cols_ff, cols_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WALL_W-1:0] rsp_walls_ff, rsp_walls_in;
   logic              rsp_gen_ff, rsp_gen_in;

   // Memory ports.
   logic              w_we, w_re;
   logic [AW-1:0]     w_waddr, w_raddr;
   logic [WALL_W-1:0] w_wdata, w_rdata;
   logic              s_we, s_re;
   logic [AW-1:0]     s_waddr, s_raddr;
   logic [RW+CW-1:0]  s_wdata, s_rdata;

   logic [SEED_W-1:0] req_seed;
   logic [IDX_W-1:0]  req_row, req_col;
   logic              req_accept, slot_free;
   logic [RCW-1:0]    rows_n;
   logic [CCW-1:0]    cols_n;
   logic [3:0]        dir_ok;
   logic [1:0]        probe_dir, capt_dir;
   logic [RW-1:0]     nb_row;
   logic [CW-1:0]     nb_col;
   logic [SDW-1:0]    depth_m2;
   logic [2:0]        cand_count;

   mdg_ram #(.WIDTH(WALL_W), .DEPTH(CELLS)) u_wall_ram (
      .clock  (clock),
      .wr_en  (w_we),
      .wr_addr(w_waddr),
      .wr_data(w_wdata),
      .rd_en  (w_re),
      .rd_addr(w_raddr),
      .rd_data(w_rdata)
   );

   mdg_ram #(.WIDTH(RW + CW), .DEPTH(CELLS)) u_stack_ram (
      .clock  (clock),
      .wr_en  (s_we),
      .wr_addr(s_waddr),
      .wr_data(s_wdata),
      .rd_en  (s_re),
      .rd_addr(s_raddr),
      .rd_data(s_rdata)
   );

   assign req_seed   = req_tdata[31:0];
   assign req_row    = req_tdata[36:32];
   assign req_col    = req_tdata[41:37];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_walls_ff};
   assign rsp_tuser  = rsp_gen_ff;

   // Size registers clamped to one at the low end and to the grid at the top.
   assign rows_n = (rows_ff == '0) ? RCW'(1) :
                   (int'(rows_ff) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(rows_ff);
   assign cols_n = (cols_ff == '0) ? CCW'(1) :
                   (int'(cols_ff) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(cols_ff);

   assign dir_ok[DIR_UP]    = (cur_row_ff != '0);
   assign dir_ok[DIR_DOWN]  = (int'(cur_row_ff) + 1) < int'(rows_n);
   assign dir_ok[DIR_LEFT]  = (cur_col_ff != '0);
   assign dir_ok[DIR_RIGHT] = (int'(cur_col_ff) + 1) < int'(cols_n);

   // Probe 0 is the current cell, probes 1 to 4 the neighbors; each result is
   // captured at the next probe after its read.
   assign probe_dir  = 2'(probe_ff - 3'd1);
   assign capt_dir   = 2'(probe_ff - 3'd2);
   assign nb_row     = step_row(cur_row_ff, dir_ff);
   assign nb_col     = step_col(cur_col_ff, dir_ff);
   assign depth_m2   = depth_ff - SDW'(2);
   assign cand_count = 3'($countones(fresh_ff));

   always_comb begin
      state_in     = state_ff;
      probe_in     = probe_ff;
      fresh_in     = fresh_ff;
      here_in      = here_ff;
      dir_in       = dir_ff;
      lfsr_in      = lfsr_ff;
      depth_in     = depth_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      clr_in       = clr_ff;
      gen_in       = gen_ff;
      oob_in       = oob_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_walls_in = rsp_walls_ff;
      rsp_gen_in   = rsp_gen_ff;

      w_we    = 1'b0;
      w_waddr = addr_of(cur_row_ff, cur_col_ff);
      w_wdata = WALLS_ALL;
      w_re    = 1'b0;
      w_raddr = addr_of(cur_row_ff, cur_col_ff);
      s_we    = 1'b0;
      s_waddr = depth_ff[AW-1:0];
      s_wdata = {nb_row, nb_col};
      s_re    = 1'b0;
      s_raddr = depth_m2[AW-1:0];

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ROWS_USED: rows_in = csr_wdata;
            CSR_COLS_USED: cols_in = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser == CMD_READ) begin
                  w_re    = 1'b1;
                  w_raddr = AW'(int'(req_row) * MAX_COLS + int'(req_col));
                  oob_in  = (int'(req_row) >= MAX_ROWS) || (int'(req_col) >= MAX_COLS);
                  state_in = ST_RD_DATA;
               end else begin
                  lfsr_in    = (req_seed == '0) ? SEED_W'(1) : req_seed;
                  s_we       = 1'b1;
                  s_waddr    = '0;
                  s_wdata    = '0;
                  depth_in   = SDW'(1);
                  cur_row_in = '0;
                  cur_col_in = '0;
                  clr_in     = '0;
                  gen_in     = 1'b1;
                  state_in   = ST_CLEAR;
               end
            end
         end
         ST_RD_DATA: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_walls_in = oob_ff ? WALLS_ALL : w_rdata;
               rsp_gen_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            w_we    = 1'b1;
            w_waddr = clr_ff;
            w_wdata = WALLS_ALL;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(CELLS - 1)) begin
               clr_in   = '0;
               probe_in = '0;
               state_in = gen_ff ? ST_SCAN : ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (probe_ff == 3'd0) begin
               w_re     = 1'b1;
               fresh_in = '0;
            end else if (probe_ff <= 3'd4) begin
               w_re    = dir_ok[probe_dir];
               w_raddr = addr_of(step_row(cur_row_ff, probe_dir),
                                 step_col(cur_col_ff, probe_dir));
            end
            if (probe_ff == 3'd1) begin
               here_in = w_rdata;
            end else if (probe_ff >= 3'd2) begin
               fresh_in[capt_dir] = dir_ok[capt_dir] && (w_rdata == WALLS_ALL);
            end
            if (probe_ff == 3'd5) begin
               state_in = ST_DECIDE;
            end else begin
               probe_in = probe_ff + 3'd1;
            end
         end
         ST_DECIDE: begin
            state_in = (fresh_ff != '0) ? ST_PICK_LFSR : ST_POP;
         end
         ST_PICK_LFSR: begin
            lfsr_in  = lfsr_step(lfsr_ff);
            state_in = ST_PICK_MOD;
         end
         ST_PICK_MOD: begin
            dir_in   = nth_dir(fresh_ff, pick_index(lfsr_ff, cand_count));
            state_in = ST_CARVE_HERE;
         end
         ST_CARVE_HERE: begin
            w_we       = 1'b1;
            w_wdata    = here_ff & ~wall_bit(dir_ff);
            cur_row_in = nb_row;
            cur_col_in = nb_col;
            if (int'(depth_ff) < CELLS) begin
               s_we     = 1'b1;
               depth_in = depth_ff + SDW'(1);
            end
            state_in = ST_CARVE_NEXT;
         end
         ST_CARVE_NEXT: begin
            // The new cell was fresh, so its old value is all walls.
            w_we     = 1'b1;
            w_wdata  = WALLS_ALL & ~wall_bit(opposite(dir_ff));
            probe_in = '0;
            state_in = ST_SCAN;
         end
         ST_POP: begin
            depth_in = depth_ff - SDW'(1);
            if (depth_ff == SDW'(1)) begin
               state_in = ST_FIN_RD0;
            end else begin
               s_re     = 1'b1;
               state_in = ST_POP_LOAD;
            end
         end
         ST_POP_LOAD: begin
            cur_row_in = s_rdata[RW+CW-1:CW];
            cur_col_in = s_rdata[CW-1:0];
            probe_in   = '0;
            state_in   = ST_SCAN;
         end
         ST_FIN_RD0: begin
            w_re     = 1'b1;
            w_raddr  = '0;
            state_in = ST_FIN_WR0;
         end
         ST_FIN_WR0: begin
            w_we     = 1'b1;
            w_waddr  = '0;
            w_wdata  = w_rdata & ~wall_bit(DIR_UP);
            state_in = ST_FIN_RD1;
         end
         ST_FIN_RD1: begin
            w_re     = 1'b1;
            w_raddr  = addr_of(RW'(rows_n - RCW'(1)), CW'(cols_n - CCW'(1)));
            state_in = ST_FIN_WR1;
         end
         ST_FIN_WR1: begin
            w_waddr = addr_of(RW'(rows_n - RCW'(1)), CW'(cols_n - CCW'(1)));
            w_wdata = w_rdata & ~wall_bit(DIR_DOWN);
            if (slot_free) begin
               w_we         = 1'b1;
               cur_row_in   = '0;
               cur_col_in   = '0;
               gen_in       = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_walls_in = WALLS_NONE;
               rsp_gen_in   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         probe_ff     <= '0;
         depth_ff     <= '0;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         lfsr_ff      <= SEED_W'(1);
         clr_ff       <= '0;
         gen_ff       <= 1'b0;
         rows_ff      <= CFG_W'(32);
         cols_ff      <= CFG_W'(32);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         probe_ff     <= probe_in;
         depth_ff     <= depth_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         lfsr_ff      <= lfsr_in;
         clr_ff       <= clr_in;
         gen_ff       <= gen_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fresh_ff     <= fresh_in;
      here_ff      <= here_in;
      dir_ff       <= dir_in;
      oob_ff       <= oob_in;
      rsp_walls_ff <= rsp_walls_in;
      rsp_gen_ff   <= rsp_gen_in;
   end

`ifndef NO_ASSERTIONS
   // A read and a write of the same wall entry never share a cycle.
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (w_we && w_re) |-> (w_waddr != w_raddr))
      else $error("wall memory read and write hit the same entry");

   // The walk only decides with the start cell still on the stack.
   a_decide_depth: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) |-> (depth_ff != '0))
      else $error("walk step with an empty stack");

   // A finished generate shows up as a response with its done flag.
   a_gen_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN_WR1 && slot_free) |=> (rsp_tvalid && rsp_tuser))
      else $error("generate finished without its response");

   // No request is taken while the memory sweep runs.
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("request accepted during the clearing sweep");
`endif

endmodule
